[sv/asin_pkg.sv]
// Shared constants for the arcsin series summation block.
`default_nettype none
package asin_pkg;

    // Fixed-point format: 30 fraction bits (Q1.30 arguments and terms, Q2.30 signed sum output).
    localparam int FRAC_BITS = 30;

    // Port widths.
    localparam int XW     = 31;   // input argument and term magnitudes
    localparam int SW     = 32;   // signed sum output
    localparam int TU_W   = 7;    // terms_used output
    localparam int TC_W   = 7;    // term_count register
    localparam int TOL_W  = 31;   // tolerance register
    localparam int CFG_IW = 2;    // configuration register index
    localparam int CFG_DW = 31;   // configuration write data

    // Shared multiplier operand width.
    localparam int MUL_W = 32;

    // Configuration register indexes.
    localparam logic [CFG_IW-1:0] CFG_STOP_MODE  = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_TERM_COUNT = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_TOLERANCE  = 2'd2;

    // Reset values of the configuration registers.
    localparam logic             RST_STOP_MODE  = 1'b0;
    localparam logic [TC_W-1:0]  RST_TERM_COUNT = 7'd8;
    localparam logic [TOL_W-1:0] RST_TOLERANCE  = 31'd1074;

endpackage
`default_nettype wire

[sv/asin_mul.sv]
// Shared unsigned multiplier with a registered product.
`default_nettype none
module asin_mul
(
    input  wire logic                          clk,
    input  wire logic [asin_pkg::MUL_W-1:0]    a,
    input  wire logic [asin_pkg::MUL_W-1:0]    b,
    output logic      [2*asin_pkg::MUL_W-1:0]  prod
);

    logic [2*asin_pkg::MUL_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

    assign prod = prod_reg;

endmodule
`default_nettype wire

[sv/arcsin_series_sum.sv]
// Top level: iterative fixed-point Maclaurin series of arcsin(x).
//
// A request is accepted at a rising edge with start high and busy low; it
// carries sine_value, a signed Q1.30 argument. The block sums the series on
// one shared 32x32 multiplier and raises done for exactly one cycle with
// arcsin_estimate (signed Q2.30), terms_used and hit_limit. The receiver
// cannot stall, so the result is only valid in the cycle done is high.
// Configuration writes on cfg_valid/cfg_ready (always ready) select the
// register by cfg_index: stop mode, term count, tolerance. The user must
// make them only while the block is idle; the block does not enforce it.
// Each added term passes through the states CHECK, P, MQ, MN, MM and CORR:
// x^2 scaling, a reciprocal-table estimate of the ratio, two products for
// the exact remainder check, and the correction and stop test. A new request
// may be accepted in the cycle done is high. In tolerance mode the number of
// terms added is at most MAX_TERMS. Reset returns the sequencer to idle,
// clears done and loads the default configuration.
`default_nettype none
module arcsin_series_sum
#(
    parameter int MAX_TERMS = 64
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic signed [asin_pkg::XW-1:0]    sine_value,
    output logic                                   done,
    output logic signed      [asin_pkg::SW-1:0]    arcsin_estimate,
    output logic             [asin_pkg::TU_W-1:0]  terms_used,
    output logic                                   hit_limit,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic        [asin_pkg::CFG_IW-1:0] cfg_index,
    input  wire logic        [asin_pkg::CFG_DW-1:0] cfg_data
);

    localparam int XW    = asin_pkg::XW;
    localparam int MW    = asin_pkg::MUL_W;
    localparam int PW    = 2 * asin_pkg::MUL_W;
    localparam int UW    = $clog2(MAX_TERMS + 1);
    localparam int LW    = (UW > asin_pkg::TC_W) ? UW : asin_pkg::TC_W;
    localparam int IDX_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int OW    = $clog2((2 * MAX_TERMS - 1) * (2 * MAX_TERMS - 1) + 1);
    localparam int DW    = $clog2((2 * MAX_TERMS) * (2 * MAX_TERMS + 1) + 1);
    localparam logic [PW-1:0] ROUND_HALF = PW'(1) << (asin_pkg::FRAC_BITS - 1);

    typedef enum logic [7:0]
    {
        S_IDLE  = 8'b0000_0001,
        S_X2    = 8'b0000_0010,
        S_CHECK = 8'b0000_0100,
        S_P     = 8'b0000_1000,
        S_MQ    = 8'b0001_0000,
        S_MN    = 8'b0010_0000,
        S_MM    = 8'b0100_0000,
        S_CORR  = 8'b1000_0000
    } state_t;

    // Per-term constants: (2i+1)^2, (2i+2)(2i+3) and floor(2^32 * ratio).
    logic [OW-1:0] odd2_tab [MAX_TERMS];
    logic [DW-1:0] den_tab  [MAX_TERMS];
    logic [MW-1:0] rq_tab   [MAX_TERMS];

    genvar gi;
    generate
        for (gi = 0; gi < MAX_TERMS; gi++)
        begin : g_tab
            localparam longint unsigned ODD  = 64'(2 * gi + 1);
            localparam longint unsigned ODD2 = ODD * ODD;
            localparam longint unsigned DEN  = (ODD + 1) * (ODD + 2);
            localparam longint unsigned RQ   = (ODD2 << 32) / DEN;
            assign odd2_tab[gi] = OW'(ODD2);
            assign den_tab[gi]  = DW'(DEN);
            assign rq_tab[gi]   = MW'(RQ);
        end
    endgenerate

    state_t                     state_reg, state_next;
    logic                       stop_mode_reg;
    logic [asin_pkg::TC_W-1:0]  term_count_reg;
    logic [asin_pkg::TOL_W-1:0] tolerance_reg;

    logic                       neg_reg, neg_next;
    logic [XW-1:0]              mag_reg, mag_next;
    logic [XW-1:0]              x2_reg, x2_next;
    logic [XW-1:0]              term_reg, term_next;
    logic [XW-1:0]              sum_reg, sum_next;
    logic [XW-1:0]              p_reg, p_next;
    logic [XW-1:0]              qe_reg, qe_next;
    logic [PW-1:0]              n_reg, n_next;
    logic [UW-1:0]              used_reg, used_next;
    logic [LW-1:0]              nlim_reg, nlim_next;
    logic                       done_reg, done_next;
    logic [asin_pkg::SW-1:0]    est_reg, est_next;
    logic [asin_pkg::TU_W-1:0]  tu_reg, tu_next;
    logic                       hit_reg, hit_next;

    logic [MW-1:0]              mul_a, mul_b;
    logic [PW-1:0]              prod;
    logic [PW-1:0]              prod_rnd;
    logic [XW-1:0]              prod_fix;
    logic [XW-1:0]              raw_in, mag_in;
    logic [IDX_W-1:0]           idx;
    logic [XW:0]                sum_add;
    logic                       term_ok, at_max, go;
    logic [asin_pkg::SW-1:0]    sum_ext;

    asin_mul u_mul
    (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    assign raw_in   = $unsigned(sine_value);
    assign mag_in   = raw_in[XW-1] ? (~raw_in + XW'(1)) : raw_in;
    assign idx      = used_reg[IDX_W-1:0];
    assign prod_rnd = prod + ROUND_HALF;
    assign prod_fix = prod_rnd[asin_pkg::FRAC_BITS +: XW];
    assign sum_add  = {1'b0, sum_reg} + {1'b0, term_reg};
    assign sum_ext  = {1'b0, sum_reg};
    assign term_ok  = term_reg >= tolerance_reg;
    assign at_max   = used_reg >= UW'(MAX_TERMS);
    assign go       = stop_mode_reg ? (term_ok && !at_max) : (LW'(used_reg) < nlim_reg);

    always_comb
    begin
        case (state_reg)
            S_IDLE:
            begin
                mul_a = MW'(mag_in);
                mul_b = MW'(mag_in);
            end
            S_MQ:
            begin
                mul_a = MW'(p_reg);
                mul_b = rq_tab[idx];
            end
            S_MN:
            begin
                mul_a = MW'(p_reg);
                mul_b = MW'(odd2_tab[idx]);
            end
            S_MM:
            begin
                mul_a = MW'(qe_reg);
                mul_b = MW'(den_tab[idx]);
            end
            default:
            begin
                mul_a = MW'(term_reg);
                mul_b = MW'(x2_reg);
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        neg_next   = neg_reg;
        mag_next   = mag_reg;
        x2_next    = x2_reg;
        term_next  = term_reg;
        sum_next   = sum_reg;
        p_next     = p_reg;
        qe_next    = qe_reg;
        n_next     = n_reg;
        used_next  = used_reg;
        nlim_next  = nlim_reg;
        done_next  = 1'b0;
        est_next   = est_reg;
        tu_next    = tu_reg;
        hit_next   = hit_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    neg_next = raw_in[XW-1];
                    mag_next = mag_in;
                    if (32'(term_count_reg) > MAX_TERMS)
                    begin
                        nlim_next = LW'(MAX_TERMS);
                    end
                    else
                    begin
                        nlim_next = LW'(term_count_reg);
                    end
                    state_next = S_X2;
                end
            end
            S_X2:
            begin
                x2_next    = prod_fix;
                term_next  = mag_reg;
                sum_next   = '0;
                used_next  = '0;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (go)
                begin
                    // The sum magnitude saturates at the largest positive value.
                    sum_next   = sum_add[XW] ? {XW{1'b1}} : sum_add[XW-1:0];
                    state_next = S_P;
                end
                else
                begin
                    est_next   = neg_reg ? (asin_pkg::SW'(0) - sum_ext) : sum_ext;
                    tu_next    = asin_pkg::TU_W'(used_reg);
                    hit_next   = stop_mode_reg && term_ok && at_max;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_P:
            begin
                p_next     = prod_fix;
                state_next = S_MQ;
            end
            S_MQ:
            begin
                state_next = S_MN;
            end
            S_MN:
            begin
                // The table reciprocal is rounded down, so this estimate is
                // the true quotient or one below it.
                qe_next    = prod[MW +: XW];
                state_next = S_MM;
            end
            S_MM:
            begin
                n_next     = prod;
                state_next = S_CORR;
            end
            S_CORR:
            begin
                if (n_reg >= prod + PW'(den_tab[idx]))
                begin
                    term_next = qe_reg + XW'(1);
                end
                else
                begin
                    term_next = qe_reg;
                end
                used_next  = used_reg + UW'(1);
                state_next = S_CHECK;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg  <= neg_next;
        mag_reg  <= mag_next;
        x2_reg   <= x2_next;
        term_reg <= term_next;
        sum_reg  <= sum_next;
        p_reg    <= p_next;
        qe_reg   <= qe_next;
        n_reg    <= n_next;
        used_reg <= used_next;
        nlim_reg <= nlim_next;
        est_reg  <= est_next;
        tu_reg   <= tu_next;
        hit_reg  <= hit_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stop_mode_reg  <= asin_pkg::RST_STOP_MODE;
            term_count_reg <= asin_pkg::RST_TERM_COUNT;
            tolerance_reg  <= asin_pkg::RST_TOLERANCE;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                asin_pkg::CFG_STOP_MODE:  stop_mode_reg  <= cfg_data[0];
                asin_pkg::CFG_TERM_COUNT: term_count_reg <= cfg_data[asin_pkg::TC_W-1:0];
                asin_pkg::CFG_TOLERANCE:  tolerance_reg  <= cfg_data[asin_pkg::TOL_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign busy            = (state_reg != S_IDLE);
    assign cfg_ready       = 1'b1;
    assign done            = done_reg;
    assign arcsin_estimate = $signed(est_reg);
    assign terms_used      = tu_reg;
    assign hit_limit       = hit_reg;

endmodule
`default_nettype wire

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench for arcsin_series_sum: random and corner-case requests.
module testbench;

    localparam int TERM_LIMIT = 64;
    localparam int STALL_LIMIT = 4000;

    typedef struct {
        logic signed [asin_pkg::SW-1:0] estimate;
        logic [asin_pkg::TU_W-1:0]      terms;
        logic                           limit;
    } asin_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic signed [asin_pkg::XW-1:0] sine_value = '0;
    logic done;
    logic signed [asin_pkg::SW-1:0] arcsin_estimate;
    logic [asin_pkg::TU_W-1:0] terms_used;
    logic hit_limit;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [asin_pkg::CFG_IW-1:0] cfg_index = asin_pkg::CFG_STOP_MODE;
    logic [asin_pkg::CFG_DW-1:0] cfg_data = '0;

    // Shadow copy of the configuration registers.
    logic stop_mode_q = asin_pkg::RST_STOP_MODE;
    logic [asin_pkg::TC_W-1:0] count_q = asin_pkg::RST_TERM_COUNT;
    logic [asin_pkg::TOL_W-1:0] tol_q = asin_pkg::RST_TOLERANCE;

    logic [asin_pkg::XW-1:0] arg_q[$];
    asin_result_t estimate_q[$];
    int issue_count = 0;
    int accept_count = 0;
    int idle_pct = 0;
    int stall_cycles = 0;
    int errors = 0;

    arcsin_series_sum #(.MAX_TERMS(TERM_LIMIT)) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .sine_value(sine_value),
        .done(done),
        .arcsin_estimate(arcsin_estimate),
        .terms_used(terms_used),
        .hit_limit(hit_limit),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    function automatic logic [63:0] q30_round(input logic [63:0] v);
        return (v + (64'd1 << (asin_pkg::FRAC_BITS - 1))) >> asin_pkg::FRAC_BITS;
    endfunction

    // Works on magnitudes, since every term carries the sign of x.
    function automatic asin_result_t predict_arcsin(input logic [asin_pkg::XW-1:0] x);
        logic        neg;
        logic [63:0] mag;
        logic [63:0] x_sq;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] odd;
        logic [63:0] den;
        int          n;
        int          used;
        asin_result_t r;
        neg = x[asin_pkg::XW-1];
        mag = neg ? ((64'h8000_0000 - {33'd0, x}) & 64'h7FFF_FFFF) : {33'd0, x};
        x_sq = q30_round(mag * mag);
        term = mag;
        sum = 64'd0;
        used = 0;
        if (!stop_mode_q)
            n = (count_q > TERM_LIMIT) ? TERM_LIMIT : int'(count_q);
        else
            n = TERM_LIMIT;
        while (used < n && (!stop_mode_q || term >= {33'd0, tol_q}))
        begin
            sum = sum + term;
            if (sum > 64'h7FFF_FFFF)
                sum = 64'h7FFF_FFFF;
            odd = 64'(2 * used + 1);
            den = 64'((2 * used + 2) * (2 * used + 3));
            term = (q30_round(term * x_sq) * odd * odd) / den;
            used++;
        end
        r.limit = stop_mode_q && used == TERM_LIMIT && term >= {33'd0, tol_q};
        r.terms = asin_pkg::TU_W'(used);
        r.estimate = neg ? 32'd0 - sum[31:0] : sum[31:0];
        return r;
    endfunction

    // Request driver: a request stays up until it is taken.
    always @(negedge clk)
    begin
        if (!rst_n)
            start <= 1'b0;
        else if (issue_count == accept_count)
        begin
            if (arg_q.size() != 0 && $urandom_range(0, 99) >= idle_pct)
            begin
                sine_value <= arg_q.pop_front();
                start <= 1'b1;
                issue_count <= issue_count + 1;
            end
            else
                start <= 1'b0;
        end
    end

    // Monitor: shadows register writes, predicts taken requests, checks results.
    always @(posedge clk)
    begin
        asin_result_t want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    asin_pkg::CFG_STOP_MODE:  stop_mode_q <= cfg_data[0];
                    asin_pkg::CFG_TERM_COUNT: count_q <= cfg_data[asin_pkg::TC_W-1:0];
                    asin_pkg::CFG_TOLERANCE:  tol_q <= cfg_data[asin_pkg::TOL_W-1:0];
                    default: ;
                endcase
            end
            if (start && !busy)
            begin
                estimate_q.push_back(predict_arcsin(sine_value));
                accept_count <= accept_count + 1;
            end
            if (done)
            begin
                if (estimate_q.size() == 0)
                begin
                    $error("unexpected result: arcsin_estimate %0d terms_used %0d",
                        arcsin_estimate, terms_used);
                    errors++;
                end
                else
                begin
                    want = estimate_q.pop_front();
                    if (arcsin_estimate !== want.estimate)
                    begin
                        $error("arcsin_estimate: expected %0d, got %0d",
                            want.estimate, arcsin_estimate);
                        errors++;
                    end
                    if (terms_used !== want.terms)
                    begin
                        $error("terms_used: expected %0d, got %0d", want.terms, terms_used);
                        errors++;
                    end
                    if (hit_limit !== want.limit)
                    begin
                        $error("hit_limit: expected %0b, got %0b", want.limit, hit_limit);
                        errors++;
                    end
                end
            end
            if ((start && !busy) || done || (cfg_valid && cfg_ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("testbench NOT OK");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic [asin_pkg::CFG_IW-1:0] idx,
                             input logic [asin_pkg::CFG_DW-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Every request gives a result, so an empty result queue means the block is idle.
    task automatic drain();
        while (arg_q.size() != 0 || issue_count != accept_count || estimate_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic configure(input logic mode, input logic [asin_pkg::TC_W-1:0] count,
                             input logic [asin_pkg::TOL_W-1:0] tol);
        drain();
        write_reg(asin_pkg::CFG_STOP_MODE, asin_pkg::CFG_DW'(mode));
        write_reg(asin_pkg::CFG_TERM_COUNT, asin_pkg::CFG_DW'(count));
        write_reg(asin_pkg::CFG_TOLERANCE, asin_pkg::CFG_DW'(tol));
    endtask

    initial
    begin
        logic [asin_pkg::XW-1:0] mag;
        logic [asin_pkg::XW-1:0] raw;
        logic [asin_pkg::TC_W-1:0] count;
        logic [asin_pkg::TOL_W-1:0] tol;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // Reset configuration: eight terms, extremes of the argument.
        idle_pct = 15;
        arg_q.push_back(31'h0000_0000);
        arg_q.push_back(31'h3FFF_FFFF);
        arg_q.push_back(31'h4000_0001);
        arg_q.push_back(31'h4000_0000);
        arg_q.push_back(31'h0000_0001);
        arg_q.push_back(31'h7FFF_FFFF);

        // Zero terms, saturated term count, a single term.
        configure(1'b0, 7'd0, asin_pkg::RST_TOLERANCE);
        arg_q.push_back(31'h1234_5678);
        configure(1'b0, 7'd127, asin_pkg::RST_TOLERANCE);
        arg_q.push_back(31'h3FFF_FFFF);
        arg_q.push_back(31'h4000_0000);
        configure(1'b0, 7'd1, asin_pkg::RST_TOLERANCE);
        arg_q.push_back(31'h5555_5555);

        // Zero tolerance runs to the term limit, even for a zero argument.
        configure(1'b1, 7'd3, 31'd0);
        arg_q.push_back(31'h3FFF_FFFF);
        arg_q.push_back(31'h0000_0000);
        configure(1'b1, 7'd3, 31'h4000_0000);
        arg_q.push_back(31'h3FFF_FFFF);
        arg_q.push_back(31'h4000_0000);
        configure(1'b1, 7'd3, 31'h7FFF_FFFF);
        arg_q.push_back(31'h4000_0000);
        configure(1'b1, 7'd3, 31'd1);
        arg_q.push_back(31'h0000_0100);
        arg_q.push_back(31'h3FF0_0000);
        arg_q.push_back(31'h4010_0000);

        for (int phase = 0; phase < 12; phase++)
        begin
            case ($urandom_range(0, 7))
                0:       count = 7'd64;
                1:       count = 7'($urandom_range(65, 127));
                default: count = 7'($urandom_range(0, 20));
            endcase
            case ($urandom_range(0, 7))
                0:       tol = 31'd0;
                1:       tol = 31'($urandom_range(32'h4000_0000, 32'h7FFF_FFFF));
                default: tol = 31'(($urandom & 32'h7FFF_FFFF) >> $urandom_range(4, 30));
            endcase
            configure(1'($urandom_range(0, 1)), count, tol);
            idle_pct = (phase < 4) ? 15 : (phase < 8) ? 62 : 0;
            for (int k = 0; k < 50; k++)
            begin
                case ($urandom_range(0, 3))
                    0: raw = 31'($urandom);
                    1: raw = 31'($urandom_range(0, 32'h0010_0000));
                    2: raw = 31'(32'h4000_0000 - $urandom_range(0, 32'h0001_0000));
                    default: raw = 31'($urandom & 32'h3FFF_FFFF) >> $urandom_range(0, 29);
                endcase
                if (!raw[asin_pkg::XW-1] && $urandom_range(0, 1))
                begin
                    // Negate the magnitude; 2^30 maps onto exactly -1.0.
                    mag = raw;
                    raw = 31'(0) - mag;
                end
                else if (!raw[asin_pkg::XW-1] && raw[asin_pkg::XW-2])
                    raw = 31'h3FFF_FFFF;
                arg_q.push_back(raw);
            end
        end

        drain();
        repeat (20) @(posedge clk);
        if (errors == 0 && estimate_q.size() == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end
endmodule
